>>> rtl/stbs_pkg.sv
// shared constants and action codes for the sorted table search block
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int ACTION_W    = 2;
  localparam int POS_W       = 10;

  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

  // flipping the sign bit makes unsigned order match signed order
  localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

>>> rtl/stbs_if.sv
// valid/ready channel interfaces for the request and result beats
interface stbs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [stbs_pkg::ACTION_W-1:0] action;
  logic signed [stbs_pkg::DATA_W-1:0]   value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface stbs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [stbs_pkg::POS_W-1:0]   position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

>>> rtl/stbs_ram.sv
// generic simple dual-port ram with registered read
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/sorted_table_binary_search.sv
// sorted table with lower-bound binary search: clear, append and search on one channel
// A clear or an append gives no result; an append to a full table is dropped. A search is
// accepted, narrows its range by halving steps, checks the entry at the final position for
// equality and loads the result register once that register is free; a search of an empty
// table goes straight to the result register, and one of a single entry straight to the check.
// Each halving step is one read of the single table memory, which sets the pace.
// One item is worked at a time; the result register lets the next item in while a result
// still waits to be taken. No clearing pass is needed after reset.
module sorted_table_binary_search (
  input  logic              clk,
  input  logic              rst_n,
  stbs_in_if.sink           in_ch,
  stbs_out_if.source        out_ch
);
  import stbs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_EQ   = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] lo_r, lo_nxt;
  logic [ADDR_W-1:0] hi_r, hi_nxt;
  logic [ADDR_W-1:0] mid_r, mid_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic              res_found_r, res_found_nxt;
  logic [POS_W-1:0]  res_pos_r, res_pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;

  logic              accept;
  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] flipped;
  logic [ADDR_W-1:0] hi_first;
  logic [ADDR_W-1:0] lo_step;
  logic [ADDR_W-1:0] hi_step;
  logic [ADDR_W:0]   mid_sum;
  logic              out_free;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign accept          = in_ch.valid && in_ch.ready;
  assign flipped         = DATA_W'(in_ch.value) ^ SIGN_FLIP;
  assign out_free        = !out_valid_r || out_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.position = out_pos_r;

  assign wr_en    = accept && (in_ch.action == ACT_APPEND) && (count_r < CNT_W'(TABLE_DEPTH));
  assign hi_first = ADDR_W'(count_r - CNT_W'(1));

  // narrowed range after comparing the key with the entry at mid
  always_comb begin
    lo_step = lo_r;
    hi_step = hi_r;
    if (key_r <= rd_data) begin
      hi_step = mid_r;
    end else begin
      lo_step = mid_r + ADDR_W'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    mid_sum       = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.action)
            ACT_CLEAR: begin
              count_nxt = '0;
            end
            ACT_APPEND: begin
              if (wr_en) begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ACT_SEARCH: begin
              key_nxt = flipped;
              lo_nxt  = '0;
              hi_nxt  = hi_first;
              if (count_r == '0) begin
                res_found_nxt = 1'b0;
                res_pos_nxt   = '0;
                state_nxt     = S_OUT;
              end else if (hi_first == '0) begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_EQ;
              end else begin
                mid_nxt   = hi_first >> 1;
                rd_en     = 1'b1;
                rd_addr   = hi_first >> 1;
                state_nxt = S_CMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CMP: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
        rd_en  = 1'b1;
        if (lo_step < hi_step) begin
          mid_sum   = {1'b0, lo_step} + {1'b0, hi_step};
          mid_nxt   = mid_sum[ADDR_W:1];
          rd_addr   = mid_sum[ADDR_W:1];
        end else begin
          rd_addr   = lo_step;
          state_nxt = S_EQ;
        end
      end
      S_EQ: begin
        res_found_nxt = (rd_data == key_r);
        res_pos_nxt   = (rd_data == key_r) ? POS_W'(lo_r) : '0;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register: one beat waits here while the next item is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == S_OUT) && out_free) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = res_found_r;
      out_pos_nxt   = res_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    key_r       <= key_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  stbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (flipped),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

>>> sim/sorted_table_binary_search_test.sv
// testbench for sorted_table_binary_search: directed cases, random loads and searches against a lower-bound model
module sorted_table_binary_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stbs_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [DATA_W-1:0]   INT_MIN    = 32'h8000_0000;
  localparam logic [DATA_W-1:0]   INT_MAX    = 32'h7FFF_FFFF;
  localparam int                  HOLD_LEN   = 400;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [DATA_W-1:0]   value;
    bit                  drain;
  } request_t;

  typedef struct {
    logic             found;
    logic [POS_W-1:0] position;
  } search_result_t;

  logic clk;
  logic rst_n;

  stbs_in_if  in_ch ();
  stbs_out_if out_ch ();

  sorted_table_binary_search dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // mirror of the table, entries kept with the sign bit flipped
  logic [DATA_W-1:0] table_mirror [TABLE_DEPTH];
  int unsigned       mirror_count;

  request_t       req_q [$];
  search_result_t result_q [$];

  int gen_count;
  int gen_fill;
  int beats_sent;
  int results_seen;
  int searches;
  int hits;
  int mismatches;
  int send_wait;
  int rcv_wait;
  bit send_burst;
  bit rcv_burst;
  int hold_left;
  int next_hold_at;
  int holds_done;
  bit full_done;

  always #6 clk = ~clk;

  function automatic int gap_draw(bit burst);
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  // model of the table: clear, append and a lower-bound search over the mirror, applied to each accepted beat
  function automatic void apply_request(logic [ACTION_W-1:0] act, logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] key;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       mid;
    search_result_t    r;
    key = val ^ SIGN_FLIP;
    case (act)
      ACT_CLEAR: mirror_count = 0;
      ACT_APPEND: begin
        if (mirror_count < TABLE_DEPTH) begin
          table_mirror[mirror_count] = key;
          mirror_count++;
        end
      end
      ACT_SEARCH: begin
        r.found    = 1'b0;
        r.position = '0;
        if (mirror_count != 0) begin
          lo = 0;
          hi = mirror_count - 1;
          while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (key <= table_mirror[mid]) hi = mid;
            else lo = mid + 1;
          end
          if (table_mirror[lo] == key) begin
            r.found    = 1'b1;
            r.position = lo[POS_W-1:0];
          end
        end
        result_q.push_back(r);
        searches++;
        if (r.found) hits++;
      end
      default: ;
    endcase
  endfunction

  function automatic void push_req(logic [ACTION_W-1:0] act, logic [DATA_W-1:0] val);
    request_t q;
    q.action = act;
    q.value  = val;
    q.drain  = 1'b0;
    req_q.push_back(q);
    // ignored codes and dropped appends do not count toward the run length
    if (act == ACT_CLEAR) gen_fill = 0;
    if (act == ACT_APPEND && gen_fill >= TABLE_DEPTH) return;
    if (act == ACT_APPEND) gen_fill++;
    if (act != ACT_UNUSED) gen_count++;
  endfunction

  function automatic void push_drain();
    request_t q;
    q.action = ACT_CLEAR;
    q.value  = '0;
    q.drain  = 1'b1;
    req_q.push_back(q);
  endfunction

  function automatic logic [DATA_W-1:0] probe_key(int vals[$]);
    int idx;
    if (vals.size() == 0) return $urandom;
    idx = $urandom_range(0, vals.size() - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return vals[idx];
      5:             return vals[idx] + 1;
      6:             return vals[idx] - 1;
      7:             return $urandom_range(0, 1) ? INT_MIN : INT_MAX;
      default:       return $urandom;
    endcase
  endfunction

  // clear, load n values (sorted or not), append past the end, then probe
  function automatic void load_and_probe(int n, bit in_order, int overflow, int probes);
    int vals[$];
    int appended[$];
    int base;
    bit narrow;
    narrow = $urandom_range(0, 1);
    base   = $urandom;
    for (int i = 0; i < n; i++) begin
      if (narrow) vals.push_back(base + $urandom_range(0, 2 * n + 2));
      else vals.push_back($urandom);
    end
    if (n > 0 && $urandom_range(0, 7) == 0) vals[0] = INT_MIN;
    if (n > 1 && $urandom_range(0, 7) == 0) vals[n-1] = INT_MAX;
    if (in_order) vals.sort();
    push_req(ACT_CLEAR, $urandom);
    foreach (vals[i]) begin
      push_req(ACT_APPEND, vals[i]);
      appended.push_back(vals[i]);
      // search a partly loaded table now and then
      if ($urandom_range(0, 15) == 0) push_req(ACT_SEARCH, probe_key(appended));
    end
    for (int i = 0; i < overflow; i++) push_req(ACT_APPEND, $urandom);
    if (n > 0) begin
      push_req(ACT_SEARCH, vals[0]);
      push_req(ACT_SEARCH, vals[n-1]);
    end
    for (int i = 0; i < probes; i++) push_req(ACT_SEARCH, probe_key(vals));
  endfunction

  function automatic int size_pick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 70) return $urandom_range(1, 16);
    return $urandom_range(17, 100);
  endfunction

  // request driver
  always @(posedge clk) begin
    request_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_request(in_ch.action, in_ch.value);
        beats_sent++;
        send_wait = gap_draw(send_burst);
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_wait != 0) begin
          send_wait--;
          in_ch.valid <= 1'b0;
        end else if (req_q.size() != 0 && req_q[0].drain) begin
          // pause until every search in flight has returned
          in_ch.valid <= 1'b0;
          if (result_q.size() == 0) req_q.delete(0);
        end else if (req_q.size() != 0) begin
          nxt = req_q.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.action <= nxt.action;
          in_ch.value  <= nxt.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-offs so the result register fills and the input stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left    <= 0;
      next_hold_at <= 100;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (results_seen == next_hold_at && holds_done < 3) begin
      hold_left    <= HOLD_LEN;
      next_hold_at <= next_hold_at + 600;
      holds_done++;
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    search_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rcv_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing expected: found=%0b position=%0d",
                     $realtime, out_ch.found, out_ch.position);
        end else begin
          want = result_q.pop_front();
          if (out_ch.found !== want.found || out_ch.position !== want.position) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result %0d mismatch: expected found=%0b position=%0d, ",
                        "got found=%0b position=%0d"},
                       $realtime, results_seen, want.found, want.position,
                       out_ch.found, out_ch.position);
          end
        end
        rcv_wait = gap_draw(rcv_burst);
        if ($urandom_range(0, 31) == 0) rcv_burst = !rcv_burst;
      end
      if (hold_left != 0 || rcv_wait != 0) begin
        if (rcv_wait != 0) rcv_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int sel;
    int total;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_CLEAR;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    mirror_count = 0;

    // directed: empty table, signed extremes, duplicates, unused code, clear
    push_req(ACT_SEARCH, 32'd5);
    push_req(ACT_APPEND, INT_MIN);
    push_req(ACT_APPEND, 32'hFFFF_FFFF);
    push_req(ACT_APPEND, 32'd0);
    push_req(ACT_APPEND, 32'd0);
    push_req(ACT_APPEND, 32'd7);
    push_req(ACT_APPEND, INT_MAX);
    push_req(ACT_SEARCH, INT_MIN);
    push_req(ACT_SEARCH, INT_MAX);
    push_req(ACT_SEARCH, 32'd0);
    push_req(ACT_SEARCH, 32'd3);
    push_req(ACT_SEARCH, 32'h8000_0001);
    push_req(ACT_SEARCH, 32'hFFFF_FFFE);
    push_req(ACT_UNUSED, 32'hFFFF_FFFF);
    push_req(ACT_SEARCH, 32'd7);
    push_req(ACT_CLEAR, 32'hFFFF_FFFF);
    push_req(ACT_SEARCH, 32'd0);
    push_req(ACT_APPEND, 32'h5555_5555);
    push_req(ACT_SEARCH, 32'hAAAA_AAAA);
    push_req(ACT_SEARCH, 32'h5555_5555);
    push_drain();

    while (gen_count < 1800) begin
      if (!full_done && gen_count > 500) begin
        load_and_probe(TABLE_DEPTH, 1'b1, 3, 40);
        full_done = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        load_and_probe(size_pick(), 1'b1, 0, $urandom_range(1, 24));
      end else if (sel < 82) begin
        load_and_probe($urandom_range(1, 20), 1'b0, 0, $urandom_range(1, 12));
      end else if (sel < 95) begin
        repeat ($urandom_range(4, 12)) push_req(ACTION_W'($urandom_range(0, 3)), $urandom);
      end else begin
        push_drain();
      end
    end
    total = 0;
    foreach (req_q[i]) if (!req_q[i].drain) total++;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_sent < total) @(negedge clk);
    while (result_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("sent %0d request beats, checked %0d search results (%0d hits), full-table load %s",
             beats_sent, results_seen, hits, full_done ? "included" : "skipped");
    $display("searches predicted: %0d, receiver hold-offs: %0d, mismatches: %0d",
             searches, holds_done, mismatches);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout: %0d of the results still outstanding", result_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
